@@ hw/rtl/vector_reflect_refract_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the vector reflect / refract block
// Short forms of the concurrent checks used at the top level.
// ----------------------------------------------------------------------------
`ifndef VECTOR_REFLECT_REFRACT_DEFINES_SVH
`define VECTOR_REFLECT_REFRACT_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define VRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, live during reset as well.
`define VRR_ASSERT_NXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/vrr_pkg.sv @@
// ----------------------------------------------------------------------------
// vrr_pkg
// Number format, pipeline payload types and saturating helpers shared by the
// reflect / refract pipeline.
// ----------------------------------------------------------------------------
package vrr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int PW        = 66;          // working width for products and sums

    // square-root unit: two root bits resolved per stage
    localparam int SQ_PER = 2;
    localparam int RT_W   = (DW + FRAC_BITS) / 2;
    localparam int SQ_STG = (RT_W + SQ_PER - 1) / SQ_PER;
    localparam int SQ_N   = SQ_STG * SQ_PER;
    localparam int REM_W  = SQ_N + 2;
    localparam int RAD_W  = 2 * SQ_N;

    localparam logic OP_REFLECT = 1'b0;
    localparam logic OP_REFRACT = 1'b1;

    typedef logic signed [DW-1:0] t_fix;
    typedef logic signed [PW-1:0] t_wide;
    typedef logic [RAD_W-1:0]     t_rad;
    typedef logic [REM_W-1:0]     t_rem;
    typedef logic [SQ_N-1:0]      t_root;

    localparam t_fix  FIX_MAX = 32'sh7fff_ffff;
    localparam t_fix  FIX_MIN = 32'sh8000_0000;
    localparam t_wide ONE_W   = t_wide'(1) <<< FRAC_BITS;

    typedef struct packed {
        t_fix v;
        logic c;
    } t_sat;

    typedef struct packed {
        logic           op;
        t_fix [2:0]     inc;
        t_fix [2:0]     nrm;
        logic [DW-1:0]  eta;
    } t_base;

    // what the back end needs once k is known
    typedef struct packed {
        t_base      base;
        logic       tir;
        logic       sat;
        t_fix [2:0] res;
        t_fix       ed;
        logic       ed_c;
    } t_side;

    function automatic t_wide wx(input t_fix a);
        return t_wide'(a);
    endfunction

    function automatic t_sat clip32(input t_wide x);
        t_sat r;
        r.c = 1'b1;
        if (x > wx(FIX_MAX)) begin
            r.v = FIX_MAX;
        end else if (x < wx(FIX_MIN)) begin
            r.v = FIX_MIN;
        end else begin
            r.v = x[DW-1:0];
            r.c = 1'b0;
        end
        return r;
    endfunction

    // floor a full product back to the fixed-point grid, then saturate
    function automatic t_sat fmul(input t_wide prod);
        return clip32(prod >>> FRAC_BITS);
    endfunction

endpackage

@@ hw/rtl/vrr_front.sv @@
// ----------------------------------------------------------------------------
// vrr_front
// Dot product, complete reflect result, and the refract discriminant k,
// over eight register stages with at most one multiply layer per stage.
// ----------------------------------------------------------------------------
module vrr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  vrr_pkg::t_base    i_base,
    output logic              o_valid,
    input  logic              i_ready,
    output vrr_pkg::t_rad     o_rad,
    output vrr_pkg::t_side    o_side
);

    localparam int NS = 8;

    logic [NS:1]   r_v;
    logic [NS+1:1] en;

    vrr_pkg::t_base r_base [1:NS];
    logic           r_cr   [2:NS];      // clipping seen on the reflect path
    logic           r_cf   [2:NS];      // clipping seen on the refract path up to k

    logic signed [63:0] r_pi1 [0:2];
    logic [63:0]        r_esq1;
    vrr_pkg::t_fix      r_dot2;
    vrr_pkg::t_fix      r_e2 [2:5];
    logic signed [63:0] r_tn3 [0:2];
    logic signed [63:0] r_dd3;
    logic signed [64:0] r_edp3;
    vrr_pkg::t_fix      r_m4 [0:2];
    vrr_pkg::t_fix      r_dsq4;
    vrr_pkg::t_fix      r_ed  [4:NS];
    logic               r_edc [4:NS];
    vrr_pkg::t_fix      r_res [5:NS][0:2];
    vrr_pkg::t_fix      r_u5;
    logic signed [63:0] r_pu6;
    vrr_pkg::t_fix      r_p7;
    vrr_pkg::t_fix      r_k8;

    logic signed [63:0] n_pi [0:2];
    logic [63:0]        n_esq;
    vrr_pkg::t_sat      n_dot;
    vrr_pkg::t_sat      n_e2;
    vrr_pkg::t_fix      n_t;
    logic               n_ct;
    logic signed [63:0] n_tn [0:2];
    logic signed [63:0] n_dd;
    logic signed [64:0] n_edp;
    vrr_pkg::t_sat      n_m [0:2];
    vrr_pkg::t_sat      n_dsq;
    vrr_pkg::t_sat      n_ed;
    vrr_pkg::t_sat      n_res [0:2];
    vrr_pkg::t_sat      n_u;
    logic signed [63:0] n_pu;
    vrr_pkg::t_sat      n_p;
    vrr_pkg::t_sat      n_k;

    // a stage takes new data when it is empty or its successor moves on
    always_comb begin
        en[NS+1] = i_ready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = ~r_v[k] | en[k+1];
        end
    end

    always_comb begin
        vrr_pkg::t_wide sum;
        sum = '0;
        for (int c = 0; c < 3; c++) begin
            n_pi[c] = $signed(i_base.inc[c]) * $signed(i_base.nrm[c]);
            sum     = sum + (vrr_pkg::t_wide'(r_pi1[c]) >>> vrr_pkg::FRAC_BITS);
        end
        n_esq = i_base.eta * i_base.eta;
        n_dot = vrr_pkg::clip32(sum);
        n_e2  = vrr_pkg::fmul(vrr_pkg::t_wide'({2'b00, r_esq1}));

        // 2d saturates only when the top two bits of d differ
        n_ct = r_dot2[vrr_pkg::DW-1] ^ r_dot2[vrr_pkg::DW-2];
        if (n_ct) begin
            n_t = r_dot2[vrr_pkg::DW-1] ? vrr_pkg::FIX_MIN : vrr_pkg::FIX_MAX;
        end else begin
            n_t = {r_dot2[vrr_pkg::DW-2:0], 1'b0};
        end
        for (int c = 0; c < 3; c++) begin
            n_tn[c] = n_t * $signed(r_base[2].nrm[c]);
        end
        n_dd  = r_dot2 * r_dot2;
        n_edp = $signed({1'b0, r_base[2].eta}) * r_dot2;

        for (int c = 0; c < 3; c++) begin
            n_m[c] = vrr_pkg::fmul(vrr_pkg::t_wide'(r_tn3[c]));
        end
        n_dsq = vrr_pkg::fmul(vrr_pkg::t_wide'(r_dd3));
        n_ed  = vrr_pkg::fmul(vrr_pkg::t_wide'(r_edp3));

        for (int c = 0; c < 3; c++) begin
            n_res[c] = vrr_pkg::clip32(vrr_pkg::wx(r_base[4].inc[c]) - vrr_pkg::wx(r_m4[c]));
        end
        n_u = vrr_pkg::clip32(vrr_pkg::ONE_W - vrr_pkg::wx(r_dsq4));

        n_pu = r_e2[5] * r_u5;
        n_p  = vrr_pkg::fmul(vrr_pkg::t_wide'(r_pu6));
        n_k  = vrr_pkg::clip32(vrr_pkg::ONE_W - vrr_pkg::wx(r_p7));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_base[1] <= i_base;
            r_pi1     <= n_pi;
            r_esq1    <= n_esq;
        end
        if (en[2]) begin
            r_base[2] <= r_base[1];
            r_dot2    <= n_dot.v;
            r_e2[2]   <= n_e2.v;
            r_cr[2]   <= n_dot.c;
            r_cf[2]   <= n_dot.c | n_e2.c;
        end
        if (en[3]) begin
            r_base[3] <= r_base[2];
            r_tn3     <= n_tn;
            r_dd3     <= n_dd;
            r_edp3    <= n_edp;
            r_e2[3]   <= r_e2[2];
            r_cr[3]   <= r_cr[2] | n_ct;
            r_cf[3]   <= r_cf[2];
        end
        if (en[4]) begin
            r_base[4] <= r_base[3];
            for (int c = 0; c < 3; c++) begin
                r_m4[c] <= n_m[c].v;
            end
            r_dsq4    <= n_dsq.v;
            r_ed[4]   <= n_ed.v;
            r_edc[4]  <= n_ed.c;
            r_e2[4]   <= r_e2[3];
            r_cr[4]   <= r_cr[3] | n_m[0].c | n_m[1].c | n_m[2].c;
            r_cf[4]   <= r_cf[3] | n_dsq.c;
        end
        if (en[5]) begin
            r_base[5] <= r_base[4];
            for (int c = 0; c < 3; c++) begin
                r_res[5][c] <= n_res[c].v;
            end
            r_u5      <= n_u.v;
            r_ed[5]   <= r_ed[4];
            r_edc[5]  <= r_edc[4];
            r_e2[5]   <= r_e2[4];
            r_cr[5]   <= r_cr[4] | n_res[0].c | n_res[1].c | n_res[2].c;
            r_cf[5]   <= r_cf[4] | n_u.c;
        end
        if (en[6]) begin
            r_base[6] <= r_base[5];
            r_res[6]  <= r_res[5];
            r_pu6     <= n_pu;
            r_ed[6]   <= r_ed[5];
            r_edc[6]  <= r_edc[5];
            r_cr[6]   <= r_cr[5];
            r_cf[6]   <= r_cf[5];
        end
        if (en[7]) begin
            r_base[7] <= r_base[6];
            r_res[7]  <= r_res[6];
            r_p7      <= n_p.v;
            r_ed[7]   <= r_ed[6];
            r_edc[7]  <= r_edc[6];
            r_cr[7]   <= r_cr[6];
            r_cf[7]   <= r_cf[6] | n_p.c;
        end
        if (en[8]) begin
            r_base[8] <= r_base[7];
            r_res[8]  <= r_res[7];
            r_k8      <= n_k.v;
            r_ed[8]   <= r_ed[7];
            r_edc[8]  <= r_edc[7];
            r_cr[8]   <= r_cr[7];
            r_cf[8]   <= r_cf[7] | n_k.c;
        end
    end

    assign o_valid = r_v[NS];
    assign o_ready = en[1];

    always_comb begin
        o_side.base = r_base[NS];
        o_side.tir  = (r_base[NS].op == vrr_pkg::OP_REFRACT) && r_k8[vrr_pkg::DW-1];
        o_side.sat  = (r_base[NS].op == vrr_pkg::OP_REFRACT) ? r_cf[NS] : r_cr[NS];
        for (int c = 0; c < 3; c++) begin
            o_side.res[c] = r_res[NS][c];
        end
        o_side.ed   = r_ed[NS];
        o_side.ed_c = r_edc[NS];
        // negative k has no root: feed zero, the result is dropped anyway
        if (r_k8[vrr_pkg::DW-1]) begin
            o_rad = '0;
        end else begin
            o_rad = vrr_pkg::t_rad'(r_k8[vrr_pkg::DW-2:0]) << vrr_pkg::FRAC_BITS;
        end
    end

endmodule

@@ hw/rtl/vrr_sqrt.sv @@
// ----------------------------------------------------------------------------
// vrr_sqrt
// Pipelined restoring integer square root, floor result, a fixed number of
// root bits per stage; the side payload travels alongside.
// ----------------------------------------------------------------------------
module vrr_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  vrr_pkg::t_rad     i_rad,
    input  vrr_pkg::t_side    i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output vrr_pkg::t_root    o_root,
    output vrr_pkg::t_side    o_side
);

    localparam int NS = vrr_pkg::SQ_STG;

    logic [NS-1:0] r_v;
    logic [NS:0]   en;

    vrr_pkg::t_rad  x_rad  [0:NS-1];
    vrr_pkg::t_rem  x_rem  [0:NS-1];
    vrr_pkg::t_root x_root [0:NS-1];
    vrr_pkg::t_side x_side [0:NS-1];

    vrr_pkg::t_rad  r_rad  [0:NS-1];
    vrr_pkg::t_rem  r_rem  [0:NS-1];
    vrr_pkg::t_root r_root [0:NS-1];
    vrr_pkg::t_side r_side [0:NS-1];

    always_comb begin
        en[NS] = i_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            en[s] = ~r_v[s] | en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    assign x_rad[0]  = i_rad;
    assign x_rem[0]  = '0;
    assign x_root[0] = '0;
    assign x_side[0] = i_side;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        vrr_pkg::t_rad  c_rad;
        vrr_pkg::t_rem  c_rem;
        vrr_pkg::t_rem  c_trial;
        vrr_pkg::t_root c_root;

        // bring down two radicand bits, keep the root bit if the trial fits
        always_comb begin
            c_rad   = x_rad[s];
            c_rem   = x_rem[s];
            c_root  = x_root[s];
            c_trial = '0;
            for (int j = 0; j < vrr_pkg::SQ_PER; j++) begin
                c_rem   = {c_rem[vrr_pkg::REM_W-3:0], c_rad[vrr_pkg::RAD_W-1 -: 2]};
                c_rad   = c_rad << 2;
                c_trial = {c_root, 2'b01};
                if (c_rem >= c_trial) begin
                    c_rem  = c_rem - c_trial;
                    c_root = {c_root[vrr_pkg::SQ_N-2:0], 1'b1};
                end else begin
                    c_root = {c_root[vrr_pkg::SQ_N-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_rad[s]  <= c_rad;
                r_rem[s]  <= c_rem;
                r_root[s] <= c_root;
                r_side[s] <= x_side[s];
            end
        end

        if (s < NS - 1) begin : g_link
            assign x_rad[s+1]  = r_rad[s];
            assign x_rem[s+1]  = r_rem[s];
            assign x_root[s+1] = r_root[s];
            assign x_side[s+1] = r_side[s];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

@@ hw/rtl/vrr_back.sv @@
// ----------------------------------------------------------------------------
// vrr_back
// Refract tail: c = eta*d + sqrt(k), eta*I - c*N, result selection and the
// output register.
// ----------------------------------------------------------------------------
module vrr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  vrr_pkg::t_root    i_root,
    input  vrr_pkg::t_side    i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output vrr_pkg::t_fix     o_out [0:2],
    output logic              o_tir,
    output logic              o_sat
);

    localparam int NS = 4;

    logic [NS:1]   r_v;
    logic [NS+1:1] en;

    vrr_pkg::t_side r_side [1:NS-1];
    logic           r_post [1:NS-1];    // clipping after k, refract only

    vrr_pkg::t_fix      r_cf1;
    logic signed [64:0] r_ap1 [0:2];
    logic signed [63:0] r_bp2 [0:2];
    vrr_pkg::t_fix      r_a   [2:3][0:2];
    vrr_pkg::t_fix      r_b3  [0:2];
    vrr_pkg::t_fix      r_out [0:2];
    logic               r_tir;
    logic               r_sat;

    vrr_pkg::t_sat      n_cf;
    logic signed [64:0] n_ap [0:2];
    logic signed [63:0] n_bp [0:2];
    vrr_pkg::t_sat      n_a  [0:2];
    vrr_pkg::t_sat      n_b  [0:2];
    vrr_pkg::t_sat      n_r  [0:2];
    vrr_pkg::t_fix      n_out [0:2];
    logic               n_tir;
    logic               n_sat;
    logic               n_refr;

    always_comb begin
        en[NS+1] = i_ready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = ~r_v[k] | en[k+1];
        end
    end

    always_comb begin
        n_cf = vrr_pkg::clip32(vrr_pkg::wx(i_side.ed) + vrr_pkg::wx(vrr_pkg::t_fix'(i_root)));
        for (int c = 0; c < 3; c++) begin
            n_ap[c] = $signed({1'b0, i_side.base.eta}) * $signed(i_side.base.inc[c]);
            n_bp[c] = r_cf1 * $signed(r_side[1].base.nrm[c]);
            n_a[c]  = vrr_pkg::fmul(vrr_pkg::t_wide'(r_ap1[c]));
            n_b[c]  = vrr_pkg::fmul(vrr_pkg::t_wide'(r_bp2[c]));
            n_r[c]  = vrr_pkg::clip32(vrr_pkg::wx(r_a[3][c]) - vrr_pkg::wx(r_b3[c]));
        end

        n_refr = r_side[3].base.op == vrr_pkg::OP_REFRACT;
        n_tir  = n_refr && r_side[3].tir;
        for (int c = 0; c < 3; c++) begin
            if (!n_refr) begin
                n_out[c] = r_side[3].res[c];
            end else if (n_tir) begin
                n_out[c] = '0;
            end else begin
                n_out[c] = n_r[c].v;
            end
        end
        // later clipping counts only when the refract vector is really formed
        n_sat = r_side[3].sat
              | (n_refr & ~n_tir & (r_post[3] | n_r[0].c | n_r[1].c | n_r[2].c));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_side[1] <= i_side;
            r_cf1     <= n_cf.v;
            r_ap1     <= n_ap;
            r_post[1] <= i_side.ed_c | n_cf.c;
        end
        if (en[2]) begin
            r_side[2] <= r_side[1];
            r_bp2     <= n_bp;
            for (int c = 0; c < 3; c++) begin
                r_a[2][c] <= n_a[c].v;
            end
            r_post[2] <= r_post[1] | n_a[0].c | n_a[1].c | n_a[2].c;
        end
        if (en[3]) begin
            r_side[3] <= r_side[2];
            r_a[3]    <= r_a[2];
            for (int c = 0; c < 3; c++) begin
                r_b3[c] <= n_b[c].v;
            end
            r_post[3] <= r_post[2] | n_b[0].c | n_b[1].c | n_b[2].c;
        end
        if (en[4]) begin
            r_out <= n_out;
            r_tir <= n_tir;
            r_sat <= n_sat;
        end
    end

    assign o_ready = en[1];
    assign o_valid = r_v[NS];
    assign o_out   = r_out;
    assign o_tir   = r_tir;
    assign o_sat   = r_sat;

endmodule

@@ hw/rtl/vector_reflect_refract.sv @@
// Path: front end, square-root pipeline (two root bits a stage), back end.
// Throughput: one beat per cycle unless the output stalls; every stage moves on as soon
//   as the next has room.
// Reset: synchronous, active low; clears all stage valid bits, payload is left as is.
// ----------------------------------------------------------------------------
// vector_reflect_refract
// Reflect or refract of a 3-component Q16.16 vector about a surface normal,
// with saturation and total-internal-reflection flags.
// ----------------------------------------------------------------------------
`include "vector_reflect_refract_defines.svh"

module vector_reflect_refract (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [31:0] i_inc_x,
    input  logic [31:0] i_inc_y,
    input  logic [31:0] i_inc_z,
    input  logic [31:0] i_nrm_x,
    input  logic [31:0] i_nrm_y,
    input  logic [31:0] i_nrm_z,
    input  logic [31:0] i_index_ratio,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z,
    output logic        o_total_internal,
    output logic        o_saturated
);

    vrr_pkg::t_base base;
    vrr_pkg::t_rad  fr_rad;
    vrr_pkg::t_side fr_side;
    vrr_pkg::t_side sq_side;
    vrr_pkg::t_root sq_root;
    vrr_pkg::t_fix  bk_out [0:2];
    logic           fr_valid;
    logic           sq_ready;
    logic           sq_valid;
    logic           bk_ready;

    always_comb begin
        base.op     = i_opcode;
        base.inc[0] = i_inc_x;
        base.inc[1] = i_inc_y;
        base.inc[2] = i_inc_z;
        base.nrm[0] = i_nrm_x;
        base.nrm[1] = i_nrm_y;
        base.nrm[2] = i_nrm_z;
        base.eta    = i_index_ratio;
    end

    vrr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_base  (base),
        .o_valid (fr_valid),
        .i_ready (sq_ready),
        .o_rad   (fr_rad),
        .o_side  (fr_side)
    );

    vrr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (sq_ready),
        .i_rad   (fr_rad),
        .i_side  (fr_side),
        .o_valid (sq_valid),
        .i_ready (bk_ready),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    vrr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .o_ready (bk_ready),
        .i_root  (sq_root),
        .i_side  (sq_side),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (bk_out),
        .o_tir   (o_total_internal),
        .o_sat   (o_saturated)
    );

    assign o_out_x = bk_out[0];
    assign o_out_y = bk_out[1];
    assign o_out_z = bk_out[2];

    // total internal reflection must come out as the zero vector
    `VRR_ASSERT_IMP(a_tir_zero, i_clk, i_rst_n, o_valid && o_total_internal, (o_out_x == '0) && (o_out_y == '0) && (o_out_z == '0), "total internal reflection beat carries a non-zero vector")

    // input back-pressure only when every stage is full and the output is stalled
    `VRR_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, !o_ready, o_valid && !i_ready, "input stalled while the pipeline still had room")

    // reset empties the pipeline
    `VRR_ASSERT_NXT(a_rst_empty, i_clk, !i_rst_n, !o_valid, "result beat offered straight after reset")

endmodule
